@@ sv/adam_step_element_update_defines.svh @@
// assertion macros for the adam element update block
// no dependencies; included by the top level only
`ifndef ADAM_STEP_ELEMENT_UPDATE_DEFINES_SVH
`define ADAM_STEP_ELEMENT_UPDATE_DEFINES_SVH

// same-cycle implication
`define ASU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/adam_seu_pkg.sv @@
// constants, types and step functions for the adam element update
// no dependencies
package adam_seu_pkg;

    localparam int NUM_ELEM   = 4096;
    localparam int IDX_W      = $clog2(NUM_ELEM);
    localparam int SQ_STAGES  = 16;
    localparam int DIV_STAGES = 24;
    localparam int QUO_W      = 48;

    localparam logic [16:0] B1_KEEP = 17'd58982;
    localparam logic [12:0] B1_NEW  = 13'd6554;
    localparam logic [20:0] B2_KEEP = 21'd1047527;
    localparam logic [10:0] B2_NEW  = 11'd1049;

    localparam logic signed [31:0] DMAX = 32'sh7fffffff;
    localparam logic signed [31:0] DMIN = 32'sh80000000;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_STEP    = 2'd1;
    localparam logic [1:0] CFG_POS_UPD = 2'd2;

    typedef struct packed {
        logic signed [31:0] m;
        logic signed [31:0] pgd;
        logic signed [31:0] x;
        logic               flag;
    } t_side;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic [32:0]      rem;
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] num;
    } t_dv;

    // one root bit from the next two radicand bits
    function automatic t_sq sq_step(t_sq s, logic [1:0] b);
        logic [35:0] r2;
        logic [35:0] t;
        t_sq         res;
        r2 = {s.rem, b};
        t  = {2'b00, s.root, 2'b01};
        if (r2 >= t) begin
            res.rem  = 34'(r2 - t);
            res.root = {s.root[30:0], 1'b1};
        end else begin
            res.rem  = r2[33:0];
            res.root = {s.root[30:0], 1'b0};
        end
        return res;
    endfunction

    // one quotient bit of restoring division
    function automatic t_dv div_step(t_dv s, logic [32:0] d);
        logic [33:0] r2;
        t_dv         res;
        r2      = {s.rem, s.num[QUO_W-1]};
        res.num = {s.num[QUO_W-2:0], 1'b0};
        if (r2 >= {1'b0, d}) begin
            res.rem = 33'(r2 - {1'b0, d});
            res.quo = {s.quo[QUO_W-2:0], 1'b1};
        end else begin
            res.rem = r2[32:0];
            res.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

@@ sv/adam_step_element_update.sv @@
// adam element update, top level: moment stores, root and divide pipelines
// depends on adam_seu_pkg and adam_step_element_update_defines.svh
//
// Usage
//   Input channel: i_valid / o_stall with element index, gradient and position
//   (signed Q16.16). A beat is taken when i_valid is high and o_stall low.
//   Output channel: o_valid / i_stall with direction, new position and the
//   saturation flag, one result beat per input beat, in order.
//   Configuration: i_cfg_valid / o_cfg_ready (always ready), index 0 mode,
//   1 step size, 2 position update enable; write only while idle.
//   One beat a cycle is taken while o_stall stays low. In Adam mode an index
//   that matches one of the three items whose moments are still being
//   computed is held off until that item writes its store entry; the memory
//   read-modify-write loop makes this interlock necessary.
//   After reset the moment memories are swept to zero, one entry a cycle,
//   with o_stall high. Configuration writes are taken meanwhile.
//   When the receiver stalls a valid result, the whole pipeline freezes and
//   o_stall rises; nothing is lost or repeated.
`include "adam_step_element_update_defines.svh"

module adam_step_element_update
    import adam_seu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [IDX_W-1:0]        i_element_index,
    input  logic signed [31:0]      i_gradient,
    input  logic signed [31:0]      i_position,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [31:0]      o_direction,
    output logic signed [31:0]      o_new_position,
    output logic                    o_saturated,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    // configuration and clearing state
    logic             r_mode;
    logic [30:0]      r_step;
    logic             r_pos_upd;
    logic             r_clr;
    logic [IDX_W-1:0] r_clr_cnt;

    // moment stores
    logic signed [31:0] mem_m [0:NUM_ELEM-1];
    logic [63:0]        mem_s [0:NUM_ELEM-1];
    logic signed [31:0] r_m_rd;
    logic [63:0]        r_s_rd;

    // front stages
    logic               rA_v, rB_v, rC_v;
    logic [IDX_W-1:0]   rA_idx, rB_idx, rC_idx;
    logic signed [31:0] rA_g, rA_x, rB_x, rC_x;
    logic signed [49:0] rB_pm;
    logic signed [46:0] rB_pg;
    logic [63:0]        rB_q;
    logic [52:0]        rB_sh, rB_sl, rC_sh, rC_sl;
    logic signed [31:0] rB_pgd, rC_pgd, rC_m;
    logic               rB_fgd, rC_fgd, rC_fm;
    logic [42:0]        rC_qh, rC_ql;

    // root and divide pipelines
    logic        r_sq_v    [0:SQ_STAGES];
    logic [63:0] r_sq_rad  [0:SQ_STAGES];
    t_sq         r_sq_st   [0:SQ_STAGES];
    t_side       r_sq_side [0:SQ_STAGES];
    logic        r_dv_v    [0:DIV_STAGES];
    logic [32:0] r_dv_d    [0:DIV_STAGES];
    t_dv         r_dv_st   [0:DIV_STAGES];
    t_side       r_dv_side [0:DIV_STAGES];

    // back stages
    logic               rF_v, rG_v, r_vo;
    logic signed [31:0] rF_p, rF_x, rG_x, rG_p;
    logic               rF_flag, rG_flag;
    logic signed [63:0] rG_prod;

    logic               en, hazard, acc, mem_we;
    logic signed [49:0] w_pm;
    logic signed [46:0] w_pg;
    logic [31:0]        w_gmag;
    logic signed [50:0] w_msum;
    logic signed [34:0] w_msh;
    logic [53:0]        w_a, w_l;
    logic [63:0]        w_snew;
    logic [32:0]        w_d;
    logic [31:0]        w_mmag;
    logic [QUO_W-1:0]   w_num;
    logic [QUO_W-1:0]   w_q;
    t_side              w_fs;
    logic signed [63:0] w_t;
    logic signed [47:0] w_rs;
    logic signed [48:0] w_np;

    // handshake and hazard interlock
    assign en     = !(r_vo && i_stall);
    assign hazard = !r_mode && ((rA_v && rA_idx == i_element_index)
                             || (rB_v && rB_idx == i_element_index)
                             || (rC_v && rC_idx == i_element_index));
    assign o_stall     = !en || r_clr || hazard;
    assign acc         = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_step    <= 31'd655;
            r_pos_upd <= 1'b1;
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:    r_mode    <= i_cfg_data[0];
                    CFG_STEP:    r_step    <= i_cfg_data[30:0];
                    CFG_POS_UPD: r_pos_upd <= i_cfg_data[0];
                    default:     ;
                endcase
            end
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == IDX_W'(NUM_ELEM - 1)) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    // moment memories: one write port, registered read
    assign mem_we = r_clr || (en && rC_v && !r_mode);
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_m[r_clr ? r_clr_cnt : rC_idx] <= r_clr ? 32'sd0 : rC_m;
            mem_s[r_clr ? r_clr_cnt : rC_idx] <= r_clr ? 64'd0 : w_snew;
        end
        if (en) begin
            r_m_rd <= mem_m[i_element_index];
            r_s_rd <= mem_s[i_element_index];
        end
    end

    // stage products
    assign w_pm   = $signed({1'b0, B1_KEEP}) * r_m_rd;
    assign w_pg   = $signed({1'b0, B1_NEW}) * rA_g;
    assign w_gmag = rA_g[31] ? 32'(-rA_g) : rA_g;

    // first moment rounding
    assign w_msum = 51'(rB_pm) + 51'(rB_pg) + 51'sd32768;
    assign w_msh  = w_msum[50:16];

    // second moment blend
    assign w_a    = 54'(rC_sh) + 54'(rC_qh);
    assign w_l    = 54'(rC_sl) + 54'(rC_ql) + 54'd524288;
    assign w_snew = {w_a[51:0], 12'd0} + {30'd0, w_l[53:20]};

    // front pipeline: read, multiply, blend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
            rB_v <= 1'b0;
            rC_v <= 1'b0;
        end else if (en) begin
            rA_v <= acc;
            rB_v <= rA_v;
            rC_v <= rB_v;
        end
        if (en) begin
            rA_idx <= i_element_index;
            rA_g   <= i_gradient;
            rA_x   <= i_position;

            rB_idx <= rA_idx;
            rB_x   <= rA_x;
            rB_pm  <= w_pm;
            rB_pg  <= w_pg;
            rB_q   <= w_gmag * w_gmag;
            rB_sh  <= r_s_rd[63:32] * B2_KEEP;
            rB_sl  <= r_s_rd[31:0] * B2_KEEP;
            rB_fgd <= (rA_g == DMIN);
            rB_pgd <= (rA_g == DMIN) ? DMAX : -rA_g;

            rC_idx <= rB_idx;
            rC_x   <= rB_x;
            rC_sh  <= rB_sh;
            rC_sl  <= rB_sl;
            rC_qh  <= rB_q[63:32] * B2_NEW;
            rC_ql  <= rB_q[31:0] * B2_NEW;
            rC_pgd <= rB_pgd;
            rC_fgd <= rB_fgd;
            if ((w_msh[34:31] == '0) || (w_msh[34:31] == '1)) begin
                rC_m  <= w_msh[31:0];
                rC_fm <= 1'b0;
            end else begin
                rC_m  <= w_msh[34] ? DMIN : DMAX;
                rC_fm <= 1'b1;
            end
        end
    end

    // root pipeline entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= rC_v;
        end
        if (en) begin
            r_sq_rad[0]       <= w_snew;
            r_sq_st[0]        <= '0;
            r_sq_side[0].m    <= rC_m;
            r_sq_side[0].pgd  <= rC_pgd;
            r_sq_side[0].x    <= rC_x;
            r_sq_side[0].flag <= r_mode ? rC_fgd : rC_fm;
        end
    end

    // root pipeline: two root bits a stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            if (en) begin
                r_sq_rad[k+1]  <= {r_sq_rad[k][59:0], 4'd0};
                r_sq_st[k+1]   <= sq_step(sq_step(r_sq_st[k], r_sq_rad[k][63:62]),
                                          r_sq_rad[k][61:60]);
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    // divisor and rounded dividend
    assign w_d    = {1'b0, r_sq_st[SQ_STAGES].root} + 33'd1;
    assign w_mmag = r_sq_side[SQ_STAGES].m[31] ? 32'(-r_sq_side[SQ_STAGES].m)
                                               : r_sq_side[SQ_STAGES].m;
    assign w_num  = {w_mmag, 16'd0} + {16'd0, w_d[32:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[SQ_STAGES];
        end
        if (en) begin
            r_dv_d[0]      <= w_d;
            r_dv_st[0].rem <= '0;
            r_dv_st[0].quo <= '0;
            r_dv_st[0].num <= w_num;
            r_dv_side[0]   <= r_sq_side[SQ_STAGES];
        end
    end

    // divide pipeline: two quotient bits a stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            if (en) begin
                r_dv_d[k+1]    <= r_dv_d[k];
                r_dv_st[k+1]   <= div_step(div_step(r_dv_st[k], r_dv_d[k]), r_dv_d[k]);
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end
    end

    assign w_q  = r_dv_st[DIV_STAGES].quo;
    assign w_fs = r_dv_side[DIV_STAGES];

    // step rounding and position sum
    assign w_t  = rG_prod + 64'sd32768;
    assign w_rs = w_t[63:16];
    assign w_np = 49'(rG_x) + 49'(w_rs);

    // back pipeline: sign and clamp, step product, position update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rF_v <= 1'b0;
            rG_v <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            rF_v <= r_dv_v[DIV_STAGES];
            rG_v <= rF_v;
            r_vo <= rG_v;
        end
        if (en) begin
            rF_x <= w_fs.x;
            if (r_mode) begin
                rF_p    <= w_fs.pgd;
                rF_flag <= w_fs.flag;
            end else if (!w_fs.m[31] && w_fs.m != 32'sd0) begin
                if (w_q > QUO_W'(64'd2147483648)) begin
                    rF_p    <= DMIN;
                    rF_flag <= 1'b1;
                end else begin
                    rF_p    <= -$signed(w_q[31:0]);
                    rF_flag <= w_fs.flag;
                end
            end else begin
                if (w_q > QUO_W'(64'd2147483647)) begin
                    rF_p    <= DMAX;
                    rF_flag <= 1'b1;
                end else begin
                    rF_p    <= $signed(w_q[31:0]);
                    rF_flag <= w_fs.flag;
                end
            end

            rG_prod     <= $signed({1'b0, r_step}) * rF_p;
            rG_x        <= rF_x;
            rG_p        <= rF_p;
            rG_flag     <= rF_flag;
            o_direction <= rG_p;

            if (!r_pos_upd) begin
                o_new_position <= rG_x;
                o_saturated    <= rG_flag;
            end else if ((w_np[48:31] == '0) || (w_np[48:31] == '1)) begin
                o_new_position <= w_np[31:0];
                o_saturated    <= rG_flag;
            end else begin
                o_new_position <= w_np[48] ? DMIN : DMAX;
                o_saturated    <= 1'b1;
            end
        end
    end

    assign o_valid = r_vo;

    `ASU_ASSERT_IMPL(a_no_raw_hazard, i_clk, i_rst_n, acc && !r_mode, !(rA_v && rA_idx == i_element_index) && !(rB_v && rB_idx == i_element_index) && !(rC_v && rC_idx == i_element_index), "read of a moment entry still in flight")
    `ASU_ASSERT_IMPL(a_no_accept_clearing, i_clk, i_rst_n, r_clr, !acc && !rC_v, "item taken during memory sweep")
    `ASU_ASSERT_NEXT(a_freeze_on_stall, i_clk, i_rst_n, r_vo && i_stall, $stable(rA_v) && $stable(rG_v) && $stable(o_new_position), "pipeline moved while stalled")

endmodule

@@ verif/adam_step_element_update_test.sv @@
// self-checking testbench for the adam element update block
// depends on adam_seu_pkg and adam_step_element_update; predicts each result beat
`timescale 1ns / 1ps

module adam_step_element_update_test;
    import adam_seu_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] grad;
        logic signed [31:0] pos;
    } t_elem;

    typedef struct {
        logic signed [31:0] dir;
        logic signed [31:0] npos;
        logic               sat;
    } t_upd;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [IDX_W-1:0]   in_idx;
    logic signed [31:0] in_grad;
    logic signed [31:0] in_pos;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_dir;
    logic signed [31:0] out_npos;
    logic               out_sat;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    t_elem              pending_elems[$];
    t_upd               expected_upds[$];
    logic signed [31:0] m_store[NUM_ELEM];
    logic [63:0]        s_store[NUM_ELEM];
    logic               mdl_mode;
    logic [30:0]        mdl_step;
    logic               mdl_pos_upd;
    int                 errors;
    int                 idle_cycles;
    int                 in_gap;
    int                 out_gap;
    logic               hold_in;
    // stall seen at the last rising edge, so the driver knows if its beat went
    logic               out_stall_q;

    localparam int WATCHDOG = 20000;

    adam_step_element_update u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (out_stall),
        .i_element_index(in_idx),
        .i_gradient     (in_grad),
        .i_position     (in_pos),
        .o_valid        (out_valid),
        .i_stall        (in_stall),
        .o_direction    (out_dir),
        .o_new_position (out_npos),
        .o_saturated    (out_sat),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // clock
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint clamp32(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // floor((v + 2^15) / 2^16)
    function automatic longint round16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = x;
        root = 0;
        bitv = 64'h1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // moment update and direction for one element
    function automatic t_upd adam_update(t_elem e);
        t_upd         u;
        logic         sat;
        longint       g;
        longint       m;
        longint       p;
        longint       np;
        logic [127:0] wide;
        logic [63:0]  mag;
        logic [63:0]  sq;
        logic [63:0]  d;
        logic [63:0]  num;
        logic [63:0]  q;
        sat = 1'b0;
        g   = longint'(e.grad);
        if (mdl_mode == 1'b0) begin
            m = round16(64'sd58982 * longint'(m_store[e.idx]) + 64'sd6554 * g);
            m = clamp32(m, sat);
            m_store[e.idx] = 32'(m);
            mag  = (g < 0) ? 64'(-g) : 64'(g);
            wide = 128'(s_store[e.idx]) * 128'd1047527 + 128'(mag * mag) * 128'd1049
                 + 128'(1 << 19);
            sq   = 64'(wide >> 20);
            s_store[e.idx] = sq;
            d   = int_sqrt(sq) + 1;
            num = ((m < 0) ? 64'(-m) : 64'(m)) << 16;
            q   = (num + d / 2) / d;
            p   = (m > 0) ? -longint'(q) : longint'(q);
        end else begin
            p = -g;
        end
        p = clamp32(p, sat);
        if (mdl_pos_upd)
            np = longint'(e.pos) + round16(longint'({33'd0, mdl_step}) * p);
        else
            np = longint'(e.pos);
        np     = clamp32(np, sat);
        u.dir  = 32'(p);
        u.npos = 32'(np);
        u.sat  = sat;
        return u;
    endfunction

    // input driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_idx   <= '0;
            in_grad  <= '0;
            in_pos   <= '0;
            in_gap   <= 0;
        end else if (!in_valid || !out_stall_q) begin
            if (in_valid) in_gap <= pick_gap();
            if (in_gap > 0 && !(in_valid && !out_stall_q)) begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_elems.size() > 0 && !hold_in
                         && !(in_valid && !out_stall_q && pick_gap() > 0)) begin
                in_valid <= 1'b1;
                in_idx   <= pending_elems[0].idx;
                in_grad  <= pending_elems[0].grad;
                in_pos   <= pending_elems[0].pos;
                void'(pending_elems.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // accepted input beats feed the predictor
    always @(posedge clk) begin
        out_stall_q <= out_stall;
        if (rst_n && in_valid && !out_stall)
            expected_upds.push_back(adam_update('{in_idx, in_grad, in_pos}));
    end

    // receiver stall
    always @(negedge clk) begin
        if (!rst_n) begin
            in_stall <= 1'b0;
            out_gap  <= 0;
        end else if (out_gap > 0) begin
            in_stall <= 1'b1;
            out_gap  <= out_gap - 1;
        end else begin
            in_stall <= 1'b0;
            out_gap  <= pick_gap();
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // monitor
    always @(posedge clk) begin
        t_upd w;
        if (rst_n && out_valid && !in_stall) begin
            if (expected_upds.size() == 0) begin
                report_mismatch("unexpected beat", out_dir, 32'd0);
            end else begin
                w = expected_upds.pop_front();
                if (out_dir !== w.dir) report_mismatch("direction", out_dir, w.dir);
                if (out_npos !== w.npos) report_mismatch("new_position", out_npos, w.npos);
                if (out_sat !== w.sat) report_mismatch("saturated", out_sat, w.sat);
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !out_stall) || (out_valid && !in_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("[adam_step_element_update] ERROR");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (index)
            CFG_MODE:    mdl_mode    = data[0];
            CFG_STEP:    mdl_step    = data[30:0];
            CFG_POS_UPD: mdl_pos_upd = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for the pipeline to drain
    task automatic drain();
        while (pending_elems.size() > 0 || in_valid || expected_upds.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_elem(logic [IDX_W-1:0] idx, logic signed [31:0] g,
                            logic signed [31:0] x);
        pending_elems.push_back('{idx, g, x});
    endtask

    task automatic random_phase(int count);
        logic [IDX_W-1:0] base;
        base = IDX_W'($urandom);
        for (int i = 0; i < count; i++) begin
            // reuse a few indexes so moments build up
            if ($urandom_range(0, 1))
                add_elem(base + IDX_W'($urandom_range(0, 7)), rand_val(), rand_val());
            else
                add_elem(IDX_W'($urandom), rand_val(), rand_val());
        end
    endtask

    // stimulus
    initial begin
        errors      = 0;
        hold_in     = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_MODE;
        cfg_data    = 0;
        mdl_mode    = 1'b0;
        mdl_step    = 31'd655;
        mdl_pos_upd = 1'b1;
        for (int i = 0; i < NUM_ELEM; i++) begin
            m_store[i] = 0;
            s_store[i] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero moments, repeated index, edge indexes
        add_elem(0, 0, 0);
        add_elem(12'hfff, 32'sh7fffffff, 32'sh7fffffff);
        add_elem(12'hfff, 32'sh80000000, 32'sh80000000);
        add_elem(1, 32'sh80000000, 0);
        add_elem(1, 32'sh80000000, 32'sh7fffffff);
        add_elem(2, 32'sh00010000, 32'sh00010000);
        add_elem(2, -32'sh00010000, 0);
        add_elem(3, 1, -1);
        add_elem(12'h800, 32'sh7fffffff, 32'sh80000000);
        add_elem(12'h555, 32'shaaaaaaaa, 32'sh55555555);
        drain();
        cfg_write(CFG_MODE, 32'd1);
        add_elem(5, 32'sh80000000, 0);
        add_elem(5, 32'sh7fffffff, 32'sh7fffffff);
        add_elem(6, 32'sh00010000, 32'sh80000000);
        drain();
        cfg_write(CFG_STEP, 32'h7fffffff);
        add_elem(7, 32'sh00010000, 0);
        add_elem(7, -1, 0);
        add_elem(8, 32'sh7fffffff, 32'sh80000000);
        drain();
        cfg_write(CFG_POS_UPD, 32'd0);
        cfg_write(CFG_MODE, 32'd0);
        add_elem(9, 32'sh12345678, 32'sh80000000);
        add_elem(9, 32'shfedcba98, 32'sh7fffffff);
        drain();
        cfg_write(CFG_STEP, 32'd0);
        cfg_write(CFG_POS_UPD, 32'd1);
        add_elem(10, 32'sh7fffffff, 32'sh7fffffff);

        // random phases across settings
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            cfg_write(CFG_MODE, (ph % 4 == 3) ? 32'd1 : 32'd0);
            cfg_write(CFG_POS_UPD, (ph == 5) ? 32'd0 : 32'd1);
            case (ph % 4)
                0: cfg_write(CFG_STEP, 32'd655);
                1: cfg_write(CFG_STEP, 32'h7fffffff);
                2: cfg_write(CFG_STEP, 32'd0);
                default: cfg_write(CFG_STEP, $urandom);
            endcase
            random_phase(60);
            // sender waits for every result once per phase
            while (pending_elems.size() > 60 / 2) @(posedge clk);
            hold_in = 1'b1;
            while (in_valid || expected_upds.size() > 0) @(posedge clk);
            hold_in = 1'b0;
            random_phase(55);
        end
        drain();

        if (errors == 0)
            $display("[adam_step_element_update] OK");
        else
            $display("[adam_step_element_update] ERROR");
        $finish;
    end

endmodule

@@ adam_step_element_update.f @@
+incdir+sv
sv/adam_seu_pkg.sv
sv/adam_step_element_update.sv
verif/adam_step_element_update_test.sv
